### rtl/core/dense_matrix_multiply_defines.svh
// assertion macros for the dense matrix multiply block
`ifndef DENSE_MATRIX_MULTIPLY_DEFINES_SVH
`define DENSE_MATRIX_MULTIPLY_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, held off during reset
`define DMM_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("dense_matrix_multiply: check failed");

// next-cycle implication, held off during reset
`define DMM_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("dense_matrix_multiply: check failed");

`else

`define DMM_ASSERT_IMP(name, clk_s, rst_s, ante, cons)
`define DMM_ASSERT_NEXT(name, clk_s, rst_s, ante, cons)

`endif

`endif

### rtl/core/dmm_pkg.sv
// shared widths, codes and constants of the dense matrix multiply block
`default_nettype none

package dmm_pkg;

  // field widths
  localparam int IDX_W     = 4;
  localparam int IDX_RANGE = 1 << IDX_W;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int SUM_W     = 38;
  localparam int OP_W      = 2;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  // operation codes of an input beat
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_REQUEST = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS  = 2'd0,
    CFG_COLS  = 2'd1,
    CFG_INNER = 2'd2
  } cfg_idx_t;

endpackage

`default_nettype wire

### rtl/core/dmm_in_if.sv
// input channel: load and request beats
`default_nettype none

interface dmm_in_if;
  logic                              valid;
  logic                              ready;
  logic [dmm_pkg::OP_W-1:0]          op;
  logic [dmm_pkg::IDX_W-1:0]         row_index;
  logic [dmm_pkg::IDX_W-1:0]         col_index;
  logic [dmm_pkg::IDX_W-1:0]         inner_index;
  logic signed [dmm_pkg::ELEM_W-1:0] element_value;

  modport source (
    output valid, op, row_index, col_index, inner_index, element_value,
    input  ready
  );
  modport sink (
    input  valid, op, row_index, col_index, inner_index, element_value,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/dmm_out_if.sv
// result channel: one beat per element of C
`default_nettype none

interface dmm_out_if;
  logic                             valid;
  logic                             ready;
  logic [dmm_pkg::IDX_W-1:0]        out_row;
  logic [dmm_pkg::IDX_W-1:0]        out_col;
  logic signed [dmm_pkg::SUM_W-1:0] dot_sum;
  logic                             bad_index;

  modport source (
    output valid, out_row, out_col, dot_sum, bad_index,
    input  ready
  );
  modport sink (
    input  valid, out_row, out_col, dot_sum, bad_index,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/dense_matrix_multiply.sv
// Dense Q1.15 matrix multiply with one shared multiply-accumulate unit.
// A load beat writes one element of A or B and the block is ready again at once. A request
// beat reads one A/B pair per cycle from the two element memories and feeds a single
// 16x16 multiplier and 38-bit accumulator; the read, multiply and accumulate stages drain
// after the last read before the result beat is registered. A request with an index beyond
// the configured size skips the reads and answers with a zero sum. Input is not accepted
// while a request is in progress, but a finished result may wait on the output register
// while new beats enter. The memories come out of reset with unknown contents; read only
// elements loaded since.
`default_nettype none
`include "dense_matrix_multiply_defines.svh"

module dense_matrix_multiply #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 16,
  parameter int MAX_INNER = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dmm_pkg::CFG_W-1:0]       cfg_data,
  dmm_in_if.sink                          in_ch,
  dmm_out_if.source                       out_ch
);

  // reachable store sizes: indices are only four bits wide
  localparam int ROWS_E  = (MAX_ROWS  < dmm_pkg::IDX_RANGE) ? MAX_ROWS  : dmm_pkg::IDX_RANGE;
  localparam int COLS_E  = (MAX_COLS  < dmm_pkg::IDX_RANGE) ? MAX_COLS  : dmm_pkg::IDX_RANGE;
  localparam int INNER_E = (MAX_INNER < dmm_pkg::IDX_RANGE) ? MAX_INNER : dmm_pkg::IDX_RANGE;
  localparam int L_DEPTH = ROWS_E * INNER_E;
  localparam int R_DEPTH = INNER_E * COLS_E;
  localparam int L_AW    = (L_DEPTH > 1) ? $clog2(L_DEPTH) : 1;
  localparam int R_AW    = (R_DEPTH > 1) ? $clog2(R_DEPTH) : 1;
  localparam int CALC_W  = 2 * dmm_pkg::IDX_W + 1;
  localparam int CW      = dmm_pkg::CFG_W;
  localparam int EW      = dmm_pkg::ELEM_W;
  localparam int PW      = dmm_pkg::PROD_W;
  localparam int SW      = dmm_pkg::SUM_W;

  localparam logic [CW-1:0] ROWS_LIM  = CW'(ROWS_E);
  localparam logic [CW-1:0] COLS_LIM  = CW'(COLS_E);
  localparam logic [CW-1:0] INNER_LIM = CW'(INNER_E);
  localparam logic [CW-1:0] CFG_RESET = CW'(dmm_pkg::IDX_RANGE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // zero counts as one, anything above the store as the store size
  function automatic logic [CW-1:0] clamp_size(input logic [CW-1:0] v,
                                               input logic [CW-1:0] lim);
    logic [CW-1:0] r;
    r = v;
    if (v == '0) r = CW'(1);
    else if (v > lim) r = lim;
    return r;
  endfunction

  state_t                 state_r;
  logic [CW-1:0]          rows_r, cols_r, inner_r;
  logic [dmm_pkg::IDX_W-1:0] row_r, col_r;
  logic [CW-1:0]          nk_r, k_r;
  logic                   bad_r;
  logic                   rd_v_r, prod_v_r;
  logic signed [EW-1:0]   a_q_r, b_q_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [SW-1:0]   acc_r;
  logic                   out_valid_r, out_bad_r;
  logic [dmm_pkg::IDX_W-1:0] out_row_r, out_col_r;
  logic signed [SW-1:0]   out_sum_r;

  logic signed [EW-1:0]   left_mem  [L_DEPTH];
  logic signed [EW-1:0]   right_mem [R_DEPTH];

  logic                   in_fire, req_fire, wr_a, wr_b, issue, out_free, req_bad;
  logic [CW-1:0]          nr, nc;
  logic [CALC_W-1:0]      la_w_full, rb_w_full, la_r_full, rb_r_full;
  logic [L_AW-1:0]        la_w, la_r;
  logic [R_AW-1:0]        rb_w, rb_r;

  // handshake and decode
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    wr_a     = 1'b0;
    wr_b     = 1'b0;
    req_fire = 1'b0;
    unique case (dmm_pkg::op_t'(in_ch.op))
      dmm_pkg::OP_LOAD_A:
        wr_a = in_fire && ({1'b0, in_ch.row_index} < ROWS_LIM)
                       && ({1'b0, in_ch.inner_index} < INNER_LIM);
      dmm_pkg::OP_LOAD_B:
        wr_b = in_fire && ({1'b0, in_ch.inner_index} < INNER_LIM)
                       && ({1'b0, in_ch.col_index} < COLS_LIM);
      dmm_pkg::OP_REQUEST:
        req_fire = in_fire;
      default: ;
    endcase
  end

  // request range check against the clamped sizes
  assign nr      = clamp_size(rows_r, ROWS_LIM);
  assign nc      = clamp_size(cols_r, COLS_LIM);
  assign req_bad = ({1'b0, in_ch.row_index} >= nr) || ({1'b0, in_ch.col_index} >= nc);

  // element addresses, A row-major over inner, B inner-major over columns
  assign la_w_full = CALC_W'(in_ch.row_index) * CALC_W'(INNER_E)
                   + CALC_W'(in_ch.inner_index);
  assign rb_w_full = CALC_W'(in_ch.inner_index) * CALC_W'(COLS_E)
                   + CALC_W'(in_ch.col_index);
  assign la_r_full = CALC_W'(row_r) * CALC_W'(INNER_E) + CALC_W'(k_r);
  assign rb_r_full = CALC_W'(k_r) * CALC_W'(COLS_E) + CALC_W'(col_r);
  assign la_w      = la_w_full[L_AW-1:0];
  assign rb_w      = rb_w_full[R_AW-1:0];
  assign la_r      = la_r_full[L_AW-1:0];
  assign rb_r      = rb_r_full[R_AW-1:0];

  assign issue = (state_r == ST_RUN);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= CFG_RESET;
      cols_r  <= CFG_RESET;
      inner_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (dmm_pkg::cfg_idx_t'(cfg_index))
        dmm_pkg::CFG_ROWS:  rows_r  <= cfg_data;
        dmm_pkg::CFG_COLS:  cols_r  <= cfg_data;
        dmm_pkg::CFG_INNER: inner_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // element memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_a) left_mem[la_w] <= in_ch.element_value;
    if (wr_b) right_mem[rb_w] <= in_ch.element_value;
    if (issue) begin
      a_q_r <= left_mem[la_r];
      b_q_r <= right_mem[rb_r];
    end
  end

  // shared multiplier stage
  always_ff @(posedge clk) begin
    prod_r <= a_q_r * b_q_r;
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= issue;
      prod_v_r <= rd_v_r;
    end
  end

  // exact accumulator
  always_ff @(posedge clk) begin
    if (req_fire) acc_r <= '0;
    else if (prod_v_r) acc_r <= acc_r + {{(SW-PW){prod_r[PW-1]}}, prod_r};
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != ST_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (req_fire) begin
            row_r <= in_ch.row_index;
            col_r <= in_ch.col_index;
            nk_r  <= clamp_size(inner_r, INNER_LIM);
            bad_r <= req_bad;
            k_r   <= '0;
            state_r <= req_bad ? ST_FIN : ST_RUN;
          end
        end
        ST_RUN: begin
          k_r <= k_r + CW'(1);
          if (k_r + CW'(1) == nk_r) state_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!rd_v_r && !prod_v_r) state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_row_r   <= row_r;
            out_col_r   <= col_r;
            out_bad_r   <= bad_r;
            out_sum_r   <= bad_r ? '0 : acc_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result beat
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.dot_sum   = out_sum_r;
  assign out_ch.bad_index = out_bad_r;

  // checks
  `DMM_ASSERT_IMP(a_bad_sum_zero, clk, rst_n, out_valid_r && out_bad_r, out_sum_r == '0)
  `DMM_ASSERT_IMP(a_count_bound, clk, rst_n, state_r == ST_RUN, k_r < nk_r)
  `DMM_ASSERT_IMP(a_result_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_FIN)

endmodule

`default_nettype wire

### dv/tb_dense_matrix_multiply.sv
// self-checking testbench for the dense matrix multiply block
`timescale 1ns / 100ps

module tb_dense_matrix_multiply;

  localparam int IW    = dmm_pkg::IDX_W;
  localparam int EW    = dmm_pkg::ELEM_W;
  localparam int CW    = dmm_pkg::CFG_W;
  localparam int RANGE = dmm_pkg::IDX_RANGE;

  localparam logic [dmm_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 156;
  localparam int SETTLE       = 24;
  localparam int QUIET_LIMIT  = 2000;

  typedef struct {
    logic [dmm_pkg::OP_W-1:0] op;
    logic [IW-1:0]            row;
    logic [IW-1:0]            col;
    logic [IW-1:0]            inner;
    logic signed [EW-1:0]     value;
  } mm_beat_t;

  typedef struct {
    logic [IW-1:0]                    row;
    logic [IW-1:0]                    col;
    logic signed [dmm_pkg::SUM_W-1:0] sum;
    logic                             bad;
  } c_elem_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [dmm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0]                 cfg_data;

  dmm_in_if  in_bus ();
  dmm_out_if out_bus ();

  dense_matrix_multiply uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  // stimulus queue and expected C elements
  mm_beat_t beat_q[$];
  c_elem_t  c_due[$];
  mm_beat_t cur_beat;

  // local copy of the matrices and size registers
  logic signed [EW-1:0] mat_a [RANGE][RANGE];
  logic signed [EW-1:0] mat_b [RANGE][RANGE];
  logic [CW-1:0] size_rows, size_cols, size_inner;

  // which elements the stimulus has loaded so far
  bit a_loaded [RANGE][RANGE];
  bit b_loaded [RANGE][RANGE];

  int phase_items;
  int fail_count = 0;
  int send_gap;
  int recv_gap;
  int quiet_cycles;
  bit idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // size register as the block uses it
  function automatic int eff_size(input logic [CW-1:0] reg_val);
    if (reg_val < 1) return 1;
    if (reg_val > RANGE) return RANGE;
    return int'(reg_val);
  endfunction

  // update local matrices or compute the C element for one accepted beat
  function automatic void apply_beat(input mm_beat_t b);
    c_elem_t c;
    longint acc;
    acc = 0;
    unique case (b.op)
      dmm_pkg::OP_LOAD_A:  mat_a[b.row][b.inner] = b.value;
      dmm_pkg::OP_LOAD_B:  mat_b[b.inner][b.col] = b.value;
      dmm_pkg::OP_REQUEST: begin
        c.row = b.row;
        c.col = b.col;
        c.bad = (b.row >= eff_size(size_rows)) || (b.col >= eff_size(size_cols));
        if (!c.bad) begin
          for (int k = 0; k < eff_size(size_inner); k++)
            acc += longint'(mat_a[b.row][k]) * longint'(mat_b[k][b.col]);
        end
        c.sum = acc[dmm_pkg::SUM_W-1:0];
        c_due.push_back(c);
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [EW-1:0] rand_elem();
    unique case ($urandom_range(0, 7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      default: return EW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void push_beat(input logic [dmm_pkg::OP_W-1:0] op,
                                    input int row, col, inner,
                                    input logic signed [EW-1:0] value);
    mm_beat_t b;
    b.op    = op;
    b.row   = IW'(row);
    b.col   = IW'(col);
    b.inner = IW'(inner);
    b.value = value;
    beat_q.push_back(b);
    if (op != OP_UNKNOWN) phase_items++;
  endfunction

  function automatic void push_load_a(input int row, inner, input logic signed [EW-1:0] v);
    push_beat(dmm_pkg::OP_LOAD_A, row, $urandom_range(0, RANGE - 1), inner, v);
    a_loaded[row][inner] = 1'b1;
  endfunction

  function automatic void push_load_b(input int inner, col, input logic signed [EW-1:0] v);
    push_beat(dmm_pkg::OP_LOAD_B, $urandom_range(0, RANGE - 1), col, inner, v);
    b_loaded[inner][col] = 1'b1;
  endfunction

  // a valid request first gets any element it reads that is still unloaded
  function automatic void push_request(input int row, col);
    if (row < eff_size(size_rows) && col < eff_size(size_cols)) begin
      for (int k = 0; k < eff_size(size_inner); k++) begin
        if (!a_loaded[row][k]) push_load_a(row, k, rand_elem());
        if (!b_loaded[k][col]) push_load_b(k, col, rand_elem());
      end
    end
    push_beat(dmm_pkg::OP_REQUEST, row, col, $urandom_range(0, RANGE - 1),
              EW'($urandom_range(0, 65535)));
  endfunction

  // random mix of loads, requests and unknown ops
  function automatic void fill_phase(input int count);
    int roll;
    int row;
    int col;
    phase_items = 0;
    while (phase_items < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        push_beat(OP_UNKNOWN, $urandom_range(0, RANGE - 1), $urandom_range(0, RANGE - 1),
                  $urandom_range(0, RANGE - 1), EW'($urandom_range(0, 65535)));
      end else if (roll < 40) begin
        push_load_a($urandom_range(0, RANGE - 1), $urandom_range(0, RANGE - 1),
                    rand_elem());
      end else if (roll < 76) begin
        push_load_b($urandom_range(0, RANGE - 1), $urandom_range(0, RANGE - 1),
                    rand_elem());
      end else begin
        row = ($urandom_range(0, 4) != 0) ? $urandom_range(0, eff_size(size_rows) - 1)
                                          : $urandom_range(0, RANGE - 1);
        col = ($urandom_range(0, 4) != 0) ? $urandom_range(0, eff_size(size_cols) - 1)
                                          : $urandom_range(0, RANGE - 1);
        push_request(row, col);
      end
    end
  endfunction

  // write all three size registers, block idle
  task automatic apply_sizes(input logic [CW-1:0] r, c, k);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= dmm_pkg::CFG_ROWS;
    cfg_data  <= r;
    @(posedge clk);
    cfg_index <= dmm_pkg::CFG_COLS;
    cfg_data  <= c;
    @(posedge clk);
    cfg_index <= dmm_pkg::CFG_INNER;
    cfg_data  <= k;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_rows  = r;
    size_cols  = c;
    size_inner = k;
    @(negedge clk);
  endtask

  // sender holds off until every result is back and the block has settled
  task automatic wait_drained();
    do @(negedge clk); while (beat_q.size() != 0 || in_bus.valid || c_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid         <= 1'b0;
      in_bus.op            <= dmm_pkg::OP_LOAD_A;
      in_bus.row_index     <= '0;
      in_bus.col_index     <= '0;
      in_bus.inner_index   <= '0;
      in_bus.element_value <= '0;
      send_gap             <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) apply_beat(cur_beat);
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          cur_beat = beat_q.pop_front();
          in_bus.op            <= cur_beat.op;
          in_bus.row_index     <= cur_beat.row;
          in_bus.col_index     <= cur_beat.col;
          in_bus.inner_index   <= cur_beat.inner;
          in_bus.element_value <= cur_beat.value;
          in_bus.valid         <= 1'b1;
          if (idle_on && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 18);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : result_check
    c_elem_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      recv_gap      <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (c_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual row %0d col %0d sum %0d",
                   $time, out_bus.out_row, out_bus.out_col, out_bus.dot_sum);
          fail_count++;
        end else begin
          want = c_due.pop_front();
          if (out_bus.out_row !== want.row) begin
            $display("%0t: out_row expected %0d actual %0d", $time, want.row, out_bus.out_row);
            fail_count++;
          end
          if (out_bus.out_col !== want.col) begin
            $display("%0t: out_col expected %0d actual %0d", $time, want.col, out_bus.out_col);
            fail_count++;
          end
          if (out_bus.dot_sum !== want.sum) begin
            $display("%0t: dot_sum expected %0d actual %0d", $time, want.sum, out_bus.dot_sum);
            fail_count++;
          end
          if (out_bus.bad_index !== want.bad) begin
            $display("%0t: bad_index expected %0d actual %0d", $time, want.bad,
                     out_bus.bad_index);
            fail_count++;
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap      <= recv_gap - 1;
        out_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        recv_gap      <= $urandom_range(0, 17);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("dense_matrix_multiply: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset, directed beats, then random phases over several sizes
  initial begin
    logic [CW-1:0] r, c, k;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = dmm_pkg::CFG_ROWS;
    cfg_data             = '0;
    idle_on              = 1'b1;
    size_rows            = 5'd16;
    size_cols            = 5'd16;
    size_inner           = 5'd16;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // zero rows register acts as one row, oversized cols as full width
    apply_sizes(5'd0, 5'd31, 5'd2);
    push_beat(OP_UNKNOWN, 15, 15, 15, -16'sd1);
    push_load_a(0, 0, -16'sd32768);
    push_load_a(0, 1, -16'sd32768);
    push_load_b(0, 0, -16'sd32768);
    push_load_b(1, 0, -16'sd32768);
    push_request(0, 0);
    push_load_b(0, 15, 16'sd32767);
    push_load_b(1, 15, 16'sd32767);
    push_load_a(0, 1, 16'sd32767);
    push_request(0, 15);
    // out of range requests echo indices with zero sum
    push_request(15, 15);
    push_request(1, 0);
    // loads past the configured size still land
    push_load_a(15, 0, 16'sd0);
    push_load_a(15, 1, -16'sd1);
    push_load_a(0, 5, 16'sd32767);
    push_request(0, 0);
    push_load_a(0, 0, 16'sd1);
    push_request(0, 0);
    wait_drained();

    for (int p = 1; p <= NUM_PHASES; p++) begin
      unique case (p)
        1:       begin r = 5'd16; c = 5'd16; k = 5'd16; end
        2:       begin r = 5'd1;  c = 5'd1;  k = 5'd1;  end
        3:       begin r = 5'd31; c = 5'd0;  k = 5'd31; end
        4:       begin r = 5'd8;  c = 5'd17; k = 5'd5;  end
        default: begin
          r = CW'($urandom_range(0, 31));
          c = CW'($urandom_range(0, 31));
          k = CW'($urandom_range(0, 31));
        end
      endcase
      apply_sizes(r, c, k);
      idle_on = (p != NUM_PHASES) && (p != 6);
      fill_phase(PHASE_ITEMS);
      wait_drained();
    end

    if (fail_count == 0 && c_due.size() == 0) begin
      $display("dense_matrix_multiply: match");
    end else begin
      $display("dense_matrix_multiply: mismatch");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/dmm_pkg.sv
rtl/core/dmm_in_if.sv
rtl/core/dmm_out_if.sv
rtl/core/dense_matrix_multiply.sv
dv/tb_dense_matrix_multiply.sv
